[design/assert_macros.svh]
// assertion macros for the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked out of reset
`define KST_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, checked out of reset
`define KST_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

[design/kst_pkg.sv]
// types and constants of the keyed slot table
`default_nettype none

package kst_pkg;

  // result status codes
  localparam logic [1:0] STATUS_SAME_KEY = 2'd0;
  localparam logic [1:0] STATUS_CLAIMED  = 2'd1;
  localparam logic [1:0] STATUS_OVERFLOW = 2'd2;

  localparam int unsigned IN_DATA_W  = 152;
  localparam int unsigned OUT_DATA_W = 8;

  // slot bookkeeping entry held in the lookup ram
  typedef struct packed {
    logic [15:0] key;
    logic [2:0]  model;
    logic [31:0] end_time;
  } kst_meta_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_COMMIT,
    ST_RESULT
  } kst_state_t;

endpackage

`default_nettype wire

[design/kst_ram.sv]
// generic single write, single read ram with registered read data
`default_nettype none

module kst_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32
) (
  input  wire logic                                   clk,
  input  wire logic                                   wr_en,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]                       wr_data,
  input  wire logic                                   rd_en,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic      [WIDTH-1:0]                       rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem_r[rd_addr];
    end
  end

endmodule

`default_nettype wire

[design/keyed_slot_table_with_expiry.sv]
// keyed slot table with expiry: top level, scan sequencer and result register
//
// usage
// - in_* carries one request per transfer; the block takes one request at a
//   time and drops in_tready while it scans, commits and waits to load the result
// - cfg_* writes lifetime_ms, the time added to now_ms to form a slot end time;
//   cfg_ready is always high, write only while the block is idle
// - out_* returns one result per request: slot index and status
// - one shared compare unit walks the lookup ram one slot per cycle, pipelined
//   against the registered read; it looks for the first same-key slot and
//   notes the first free or expired slot in the same pass, stopping early on
//   a key hit
// - a key hit at slot k ends the walk there; a claim or overflow walks all
//   NUM_SLOTS slots; a hit or claim then writes the slot in the commit state,
//   overflow goes straight to the result; requests do not overlap
// - in_tready rises again once the result loads, while that result may still
//   sit in the output register
// - a stalled receiver holds the result in the output register; a later
//   request scans and commits but waits for that register before finishing
// - reset: lifetime_ms returns to 200 and all slot valid bits clear, so every
//   slot reads as key 0, no model, end time 0; no clearing pass is needed
`default_nettype none
`include "assert_macros.svh"

module keyed_slot_table_with_expiry #(
  parameter int unsigned NUM_SLOTS = 32
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  // request: entity_key[15:0] model_id[18:16] start_x[34:19] start_y[50:35]
  // start_z[66:51] end_x[82:67] end_y[98:83] end_z[114:99] now_ms[146:115]
  input  wire logic                          in_tvalid,
  output logic                               in_tready,
  input  wire logic [kst_pkg::IN_DATA_W-1:0] in_tdata,
  // result: slot_index[4:0] status[6:5]
  output logic                               out_tvalid,
  input  wire logic                          out_tready,
  output logic [kst_pkg::OUT_DATA_W-1:0]     out_tdata,
  // lifetime_ms write
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [15:0]                   cfg_data
);

  import kst_pkg::*;

  localparam int unsigned IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int unsigned CNT_W = $clog2(NUM_SLOTS + 1);
  localparam int unsigned COORD_W = 96;

  kst_state_t state_r, state_nxt;

  // latched request
  logic [15:0]        key_r;
  logic [2:0]         model_r;
  logic [47:0]        start_r;
  logic [47:0]        end_r;
  logic [31:0]        now_r;

  logic [15:0]        lifetime_r;

  // scan pipeline
  logic [CNT_W-1:0]   issue_cnt_r;
  logic               pend_r;
  logic [IDX_W-1:0]   cmp_idx_r;
  logic               rd_valid_r;
  logic               free_found_r;
  logic [IDX_W-1:0]   free_idx_r;
  logic [IDX_W-1:0]   found_idx_r;
  logic [1:0]         status_r;

  logic [NUM_SLOTS-1:0] valid_r;

  logic               out_valid_r;
  logic [4:0]         out_index_r;
  logic [1:0]         out_status_r;

  // ram ports
  logic               meta_rd_en;
  logic [IDX_W-1:0]   meta_rd_addr;
  kst_meta_t          meta_rd_data;
  logic               ram_wr_en;
  kst_meta_t          meta_wr_data;
  logic [COORD_W-1:0] coord_wr_data;

  logic               in_xfer;
  logic               issue_more;
  logic               scan_done;
  logic               key_hit;
  logic               slot_free;
  logic               out_load;
  kst_meta_t          ent;
  logic [32:0]        end_sum;
  logic [31:0]        found_ext;

  assign in_tready  = (state_r == ST_IDLE);
  assign in_xfer    = in_tvalid && in_tready;
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_status_r, out_index_r};

  // never-written slots read as all zero
  always_comb begin
    ent = rd_valid_r ? meta_rd_data : '0;
  end

  // shared compare unit, one slot per cycle
  assign issue_more = (issue_cnt_r != CNT_W'(NUM_SLOTS));
  assign key_hit    = pend_r && (ent.key == key_r);
  assign slot_free  = pend_r && ((ent.model == 3'd0) || (ent.end_time < now_r));
  assign scan_done  = !issue_more && !pend_r;
  assign out_load   = (state_r == ST_RESULT) && (!out_valid_r || out_tready);

  // end time, saturating
  assign end_sum   = {1'b0, now_r} + {17'd0, lifetime_r};
  assign found_ext = 32'(found_idx_r);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_xfer) state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        if (key_hit) begin
          state_nxt = ST_COMMIT;
        end else if (scan_done) begin
          state_nxt = free_found_r ? ST_COMMIT : ST_RESULT;
        end
      end
      ST_COMMIT: state_nxt = ST_RESULT;
      ST_RESULT: begin
        if (out_load) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // ram controls
  always_comb begin
    meta_rd_en    = (state_r == ST_SCAN) && issue_more;
    meta_rd_addr  = issue_cnt_r[IDX_W-1:0];
    ram_wr_en     = (state_r == ST_COMMIT);
    meta_wr_data.key      = key_r;
    meta_wr_data.model    = model_r;
    meta_wr_data.end_time = end_sum[32] ? 32'hFFFF_FFFF : end_sum[31:0];
    coord_wr_data = {end_r, start_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      lifetime_r  <= 16'd200;
      valid_r     <= '0;
      out_valid_r <= 1'b0;
      pend_r      <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) lifetime_r <= cfg_data;
      if (ram_wr_en) valid_r[found_idx_r] <= 1'b1;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      if (in_xfer) begin
        pend_r <= 1'b0;
      end else if (state_r == ST_SCAN) begin
        pend_r <= meta_rd_en;
      end
    end
  end

  // payload and scan bookkeeping
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      key_r        <= in_tdata[15:0];
      model_r      <= in_tdata[18:16];
      start_r      <= {in_tdata[66:51], in_tdata[50:35], in_tdata[34:19]};
      end_r        <= {in_tdata[114:99], in_tdata[98:83], in_tdata[82:67]};
      now_r        <= in_tdata[146:115];
      issue_cnt_r  <= '0;
      free_found_r <= 1'b0;
    end
    if (state_r == ST_SCAN) begin
      if (meta_rd_en) begin
        issue_cnt_r <= issue_cnt_r + CNT_W'(1);
        cmp_idx_r   <= meta_rd_addr;
        rd_valid_r  <= valid_r[meta_rd_addr];
      end
      if (slot_free && !free_found_r) begin
        free_found_r <= 1'b1;
        free_idx_r   <= cmp_idx_r;
      end
      if (key_hit) begin
        found_idx_r <= cmp_idx_r;
        status_r    <= STATUS_SAME_KEY;
      end else if (scan_done) begin
        found_idx_r <= free_found_r ? free_idx_r : '0;
        status_r    <= free_found_r ? STATUS_CLAIMED : STATUS_OVERFLOW;
      end
    end
    if (out_load) begin
      out_index_r  <= (status_r == STATUS_OVERFLOW) ? 5'd0 : found_ext[4:0];
      out_status_r <= status_r;
    end
  end

  kst_ram #(
    .WIDTH($bits(kst_meta_t)),
    .DEPTH(NUM_SLOTS)
  ) u_meta_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (found_idx_r),
    .wr_data (meta_wr_data),
    .rd_en   (meta_rd_en),
    .rd_addr (meta_rd_addr),
    .rd_data (meta_rd_data)
  );

  // coordinates are stored only
  kst_ram #(
    .WIDTH(COORD_W),
    .DEPTH(NUM_SLOTS)
  ) u_coord_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (found_idx_r),
    .wr_data (coord_wr_data),
    .rd_en   (1'b0),
    .rd_addr (found_idx_r),
    .rd_data ()
  );

  `KST_ASSERT_NEXT(a_accept_starts_scan, clk, rst_n, in_xfer, state_r == ST_SCAN)
  `KST_ASSERT_SAME(a_write_only_commit, clk, rst_n, ram_wr_en, status_r != STATUS_OVERFLOW)
  `KST_ASSERT_SAME(a_overflow_index_zero, clk, rst_n,
                   out_valid_r && (out_status_r == STATUS_OVERFLOW), out_index_r == 5'd0)
  `KST_ASSERT_NEXT(a_commit_sets_valid, clk, rst_n, ram_wr_en, valid_r[$past(found_idx_r)])

endmodule

`default_nettype wire
